@@ design/cfl_pkg.sv @@
// Shared types, constants and saturating fixed-point helpers for the CFL time step core.
package cfl_pkg;

  localparam int WORD_BITS = 32;

  typedef logic signed [WORD_BITS-1:0] word_t;

  localparam word_t WMAX = 32'sh7FFF_FFFF;
  localparam word_t WMIN = 32'sh8000_0000;

  localparam logic [1:0] STATUS_OK  = 2'd0;
  localparam logic [1:0] STATUS_SAT = 2'd1;
  localparam logic [1:0] STATUS_BAD = 2'd2;

  localparam logic [7:0] REG_CFL   = 8'd0;
  localparam logic [7:0] REG_GAMMA = 8'd1;

  typedef struct packed {
    word_t density;
    word_t momentum_x;
    word_t momentum_y;
    word_t total_energy;
    word_t base_x;
    word_t base_y;
    word_t next_j_x;
    word_t next_j_y;
    word_t next_k_x;
    word_t next_k_y;
  } in_t;

  typedef struct packed {
    logic [30:0] dt_over_volume;
    logic [1:0]  status;
  } out_t;

  // Raw product: magnitude and sign kept apart until scaling.
  typedef struct packed {
    logic        neg;
    logic [63:0] m;
  } prod_t;

  function automatic word_t sadd(word_t a, word_t b);
    logic [WORD_BITS:0] s;
    s = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
    if (s[WORD_BITS] != s[WORD_BITS-1]) begin
      return s[WORD_BITS] ? WMIN : WMAX;
    end
    return word_t'(s[WORD_BITS-1:0]);
  endfunction

  function automatic word_t ssub(word_t a, word_t b);
    logic [WORD_BITS:0] s;
    s = {a[WORD_BITS-1], a} - {b[WORD_BITS-1], b};
    if (s[WORD_BITS] != s[WORD_BITS-1]) begin
      return s[WORD_BITS] ? WMIN : WMAX;
    end
    return word_t'(s[WORD_BITS-1:0]);
  endfunction

  function automatic word_t sabs(word_t a);
    if (!a[WORD_BITS-1]) begin
      return a;
    end
    return (a == WMIN) ? WMAX : word_t'(-a);
  endfunction

  function automatic logic [WORD_BITS-1:0] mag(word_t a);
    return a[WORD_BITS-1] ? WORD_BITS'(-a) : WORD_BITS'(a);
  endfunction

  // Apply sign to a magnitude and clamp to the word range.
  function automatic word_t fmag(logic [63:0] m, logic neg);
    if (neg) begin
      if (m >= 64'h8000_0000) begin
        return WMIN;
      end
      return word_t'(32'd0 - m[31:0]);
    end
    if (m > 64'h7FFF_FFFF) begin
      return WMAX;
    end
    return word_t'(m[31:0]);
  endfunction

  function automatic logic fsat(logic [63:0] m, logic neg);
    return neg ? (m > 64'h8000_0000) : (m > 64'h7FFF_FFFF);
  endfunction

  function automatic prod_t pmul(word_t a, word_t b);
    prod_t p;
    p.neg = a[WORD_BITS-1] ^ b[WORD_BITS-1];
    p.m   = mag(a) * mag(b);
    return p;
  endfunction

  function automatic word_t qsc(prod_t p, int f);
    return fmag(p.m >> f, p.neg);
  endfunction

endpackage

@@ design/cfl_div.sv @@
// Pipelined restoring divider: (|num| << FRAC_BITS) / |den|, one quotient bit per stage.
module cfl_div #(
  parameter int FRAC_BITS = 16,
  parameter int SIDE_BITS = 1
) (
  input  logic                  clk,
  input  logic                  en,
  input  cfl_pkg::word_t        num,
  input  cfl_pkg::word_t        den,
  input  logic [SIDE_BITS-1:0]  side_in,
  output cfl_pkg::word_t        quo,
  output logic                  sat,
  output logic [SIDE_BITS-1:0]  side_out
);

  localparam int W  = cfl_pkg::WORD_BITS;
  localparam int QB = W + FRAC_BITS;

  logic [QB-1:0]        nr [0:QB];
  logic [W-1:0]         rm [0:QB];
  logic [QB-1:0]        qt [0:QB];
  logic [W-1:0]         dv [0:QB];
  logic                 ng [0:QB];
  logic [SIDE_BITS-1:0] sd [0:QB];

  always_ff @(posedge clk) begin
    if (en) begin
      nr[0] <= QB'(cfl_pkg::mag(num)) << FRAC_BITS;
      rm[0] <= '0;
      qt[0] <= '0;
      dv[0] <= cfl_pkg::mag(den);
      ng[0] <= num[W-1] ^ den[W-1];
      sd[0] <= side_in;
    end
  end

  genvar k;
  for (k = 1; k <= QB; k++) begin : g_step
    logic [W:0] trial;
    logic [W:0] diff;
    logic       ge;
    assign trial = {rm[k-1], nr[k-1][QB-1]};
    assign diff  = trial - {1'b0, dv[k-1]};
    assign ge    = trial >= {1'b0, dv[k-1]};

    always_ff @(posedge clk) begin
      if (en) begin
        rm[k] <= ge ? diff[W-1:0] : trial[W-1:0];
        qt[k] <= {qt[k-1][QB-2:0], ge};
        nr[k] <= nr[k-1] << 1;
        dv[k] <= dv[k-1];
        ng[k] <= ng[k-1];
        sd[k] <= sd[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quo      <= cfl_pkg::fmag(64'(qt[QB]), ng[QB]);
      sat      <= cfl_pkg::fsat(64'(qt[QB]), ng[QB]);
      side_out <= sd[QB];
    end
  end

endmodule

@@ design/cfl_sqrt.sv @@
// Pipelined digit-by-digit square root of (x << FRAC_BITS), one root bit per stage.
module cfl_sqrt #(
  parameter int FRAC_BITS = 16,
  parameter int SIDE_BITS = 1
) (
  input  logic                  clk,
  input  logic                  en,
  input  cfl_pkg::word_t        x,
  input  logic [SIDE_BITS-1:0]  side_in,
  output cfl_pkg::word_t        y,
  output logic [SIDE_BITS-1:0]  side_out
);

  localparam int W  = cfl_pkg::WORD_BITS;
  localparam int R  = (W + FRAC_BITS) / 2;
  localparam int RW = 2 * R;

  logic [RW-1:0]        rad [0:R];
  logic [R-1:0]         rm  [0:R];
  logic [R-1:0]         rt  [0:R];
  logic [SIDE_BITS-1:0] sd  [0:R];

  always_ff @(posedge clk) begin
    if (en) begin
      rad[0] <= (x > 0) ? (RW'($unsigned(x)) << FRAC_BITS) : '0;
      rm[0]  <= '0;
      rt[0]  <= '0;
      sd[0]  <= side_in;
    end
  end

  genvar k;
  for (k = 1; k <= R; k++) begin : g_step
    logic [R+1:0] cur;
    logic [R+1:0] trial;
    logic         ge;
    assign cur   = {rm[k-1], rad[k-1][RW-1:RW-2]};
    assign trial = {rt[k-1], 2'b01};
    assign ge    = cur >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rm[k]  <= ge ? R'(cur - trial) : R'(cur);
        rt[k]  <= {rt[k-1][R-2:0], ge};
        rad[k] <= rad[k-1] << 2;
        sd[k]  <= sd[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      y        <= W'(rt[R]);
      side_out <= sd[R];
    end
  end

endmodule

@@ design/cfl_local_timestep_2d_euler_core.sv @@
// Top level of the local CFL time step core for a 2-D Euler finite-volume cell.
// Usage:
//   in channel   (in_valid/in_ready/in_data): one request per cell, carrying the
//                conserved state and three corner points, all signed Q16.16.
//   out channel  (out_valid/out_ready/out_data): one result per request, in order:
//                dt_over_volume (unsigned Q15.16) and status (ok, saturated, invalid).
//   cfg channel  (cfg_valid/cfg_ready/cfg_index/cfg_data): index 0 writes the
//                Courant number, index 1 writes gamma; other indexes are dropped.
//                cfg_ready is always high; write only while the core is empty.
// Throughput: one cell per clock, sustained while the output is not stalled.
// Depth: mostly the three bit-per-stage dividers in series (velocity, sound
//   speed, time step) and the root stages.
// Reset (rst, synchronous): drop every request in flight, load cfl 1.0 and
//   gamma 1.4.
// Stall: while out_valid is high and out_ready low the whole pipeline holds,
//   and in_ready drops; nothing is lost or repeated.
module cfl_local_timestep_2d_euler_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  cfl_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output cfl_pkg::out_t out_data,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [7:0]    cfg_index,
  input  logic [31:0]   cfg_data
);

  localparam int W        = cfl_pkg::WORD_BITS;
  localparam int DIV_LAT  = W + FRAC_BITS + 2;
  localparam int SQRT_LAT = (W + FRAC_BITS) / 2 + 2;
  localparam int LAT      = 15 + 3 * DIV_LAT + SQRT_LAT;

  // Side data that rides along the first divider.
  typedef struct packed {
    cfl_pkg::word_t rho;
    cfl_pkg::word_t e;
    cfl_pkg::word_t sj0;
    cfl_pkg::word_t sj1;
    cfl_pkg::word_t sk0;
    cfl_pkg::word_t sk1;
  } cell_t;

  // Contravariant velocities, squared face lengths and validity.
  typedef struct packed {
    cfl_pkg::word_t uuc;
    cfl_pkg::word_t vvc;
    cfl_pkg::word_t xs2;
    cfl_pkg::word_t ys2;
    cfl_pkg::word_t rho;
    logic           bad;
  } geo_t;

  typedef struct packed {
    cfl_pkg::word_t uuc;
    cfl_pkg::word_t vvc;
  } vel_t;

  logic           en;
  logic [LAT-1:0] vld;
  logic [30:0]    cfl_reg;
  logic [17:0]    gamma_reg;

  cfl_pkg::word_t cfl_w;
  cfl_pkg::word_t g_w;
  cfl_pkg::word_t one_w;
  cfl_pkg::word_t gm1_w;

  // Whole pipeline moves together; it holds only when a result waits.
  assign en        = !out_valid || out_ready;
  assign in_ready  = en;
  assign out_valid = vld[LAT-1];
  assign cfg_ready = 1'b1;

  assign cfl_w = cfl_pkg::word_t'({1'b0, cfl_reg});
  assign g_w   = cfl_pkg::word_t'({14'd0, gamma_reg});
  assign one_w = cfl_pkg::word_t'(32'd1 << FRAC_BITS);
  assign gm1_w = cfl_pkg::ssub(g_w, one_w);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfl_reg   <= 31'd65536;
      gamma_reg <= 18'd91750;
    end else if (cfg_valid) begin
      case (cfg_index)
        cfl_pkg::REG_CFL: begin
          cfl_reg <= cfg_data[30:0];
        end
        cfl_pkg::REG_GAMMA: begin
          gamma_reg <= cfg_data[17:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Valid bits travel alongside the data stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  // Stage 1: capture the cell, form the face normals, check density.
  cell_t          p0_cell;
  cfl_pkg::word_t p0_mx;
  cfl_pkg::word_t p0_my;
  logic           p0_bad;

  always_ff @(posedge clk) begin
    if (en) begin
      p0_cell.rho <= in_data.density;
      p0_cell.e   <= in_data.total_energy;
      p0_cell.sj0 <= cfl_pkg::ssub(in_data.next_k_y, in_data.base_y);
      p0_cell.sj1 <= cfl_pkg::ssub(in_data.base_x, in_data.next_k_x);
      p0_cell.sk0 <= cfl_pkg::ssub(in_data.base_y, in_data.next_j_y);
      p0_cell.sk1 <= cfl_pkg::ssub(in_data.next_j_x, in_data.base_x);
      p0_mx       <= in_data.momentum_x;
      p0_my       <= in_data.momentum_y;
      p0_bad      <= in_data.density[W-1] || (in_data.density == '0);
    end
  end

  // Velocities u = mx / rho and v = my / rho.
  cfl_pkg::word_t u_q;
  cfl_pkg::word_t v_q;
  cell_t          b_cell;
  logic           b_bad;

  cfl_div #(.FRAC_BITS(FRAC_BITS), .SIDE_BITS($bits(cell_t))) u_div_u (
    .clk(clk), .en(en), .num(p0_mx), .den(p0_cell.rho), .side_in(p0_cell),
    .quo(u_q), .sat(), .side_out(b_cell)
  );

  cfl_div #(.FRAC_BITS(FRAC_BITS), .SIDE_BITS(1)) u_div_v (
    .clk(clk), .en(en), .num(p0_my), .den(p0_cell.rho), .side_in(p0_bad),
    .quo(v_q), .sat(), .side_out(b_bad)
  );

  // P1: all products that need only u, v and the normals.
  cfl_pkg::prod_t p1_uu, p1_vv, p1_usj0, p1_vsj1, p1_usk0, p1_vsk1;
  cfl_pkg::prod_t p1_sj0sq, p1_sj1sq, p1_sk0sq, p1_sk1sq;
  cfl_pkg::word_t p1_rho, p1_e;
  logic           p1_bad;

  always_ff @(posedge clk) begin
    if (en) begin
      p1_uu    <= cfl_pkg::pmul(u_q, u_q);
      p1_vv    <= cfl_pkg::pmul(v_q, v_q);
      p1_usj0  <= cfl_pkg::pmul(u_q, b_cell.sj0);
      p1_vsj1  <= cfl_pkg::pmul(v_q, b_cell.sj1);
      p1_usk0  <= cfl_pkg::pmul(u_q, b_cell.sk0);
      p1_vsk1  <= cfl_pkg::pmul(v_q, b_cell.sk1);
      p1_sj0sq <= cfl_pkg::pmul(b_cell.sj0, b_cell.sj0);
      p1_sj1sq <= cfl_pkg::pmul(b_cell.sj1, b_cell.sj1);
      p1_sk0sq <= cfl_pkg::pmul(b_cell.sk0, b_cell.sk0);
      p1_sk1sq <= cfl_pkg::pmul(b_cell.sk1, b_cell.sk1);
      p1_rho   <= b_cell.rho;
      p1_e     <= b_cell.e;
      p1_bad   <= b_bad;
    end
  end

  // P2: scale and sum pairs.
  cfl_pkg::word_t p2_s, p2_rho, p2_e;
  geo_t           p2_geo;

  always_ff @(posedge clk) begin
    if (en) begin
      p2_s       <= cfl_pkg::sadd(cfl_pkg::qsc(p1_uu, FRAC_BITS),
                                  cfl_pkg::qsc(p1_vv, FRAC_BITS));
      p2_geo.uuc <= cfl_pkg::sadd(cfl_pkg::qsc(p1_usj0, FRAC_BITS),
                                  cfl_pkg::qsc(p1_vsj1, FRAC_BITS));
      p2_geo.vvc <= cfl_pkg::sadd(cfl_pkg::qsc(p1_usk0, FRAC_BITS),
                                  cfl_pkg::qsc(p1_vsk1, FRAC_BITS));
      p2_geo.xs2 <= cfl_pkg::sadd(cfl_pkg::qsc(p1_sj0sq, FRAC_BITS),
                                  cfl_pkg::qsc(p1_sj1sq, FRAC_BITS));
      p2_geo.ys2 <= cfl_pkg::sadd(cfl_pkg::qsc(p1_sk0sq, FRAC_BITS),
                                  cfl_pkg::qsc(p1_sk1sq, FRAC_BITS));
      p2_geo.rho <= p1_rho;
      p2_geo.bad <= p1_bad;
      p2_rho     <= p1_rho;
      p2_e       <= p1_e;
    end
  end

  // P3..P5: kinetic energy 0.5 * rho * |V|^2, then e - ke.
  cfl_pkg::prod_t    p3_prod;
  cfl_pkg::word_t    p3_e, p4_t, p4_e, p5_ed;
  geo_t              p3_geo, p4_geo, p5_geo;
  logic [W-1:0]      ke_half;
  cfl_pkg::word_t    ke_w;

  assign ke_half = cfl_pkg::mag(p4_t) >> 1;
  assign ke_w    = p4_t[W-1] ? cfl_pkg::word_t'(-ke_half) : cfl_pkg::word_t'(ke_half);

  always_ff @(posedge clk) begin
    if (en) begin
      p3_prod <= cfl_pkg::pmul(p2_rho, p2_s);
      p3_e    <= p2_e;
      p3_geo  <= p2_geo;
      p4_t    <= cfl_pkg::qsc(p3_prod, FRAC_BITS);
      p4_e    <= p3_e;
      p4_geo  <= p3_geo;
      p5_ed   <= cfl_pkg::ssub(p4_e, ke_w);
      p5_geo  <= p4_geo;
    end
  end

  // P6..P9: pressure (gamma - 1) * (e - ke), then gamma * p.
  cfl_pkg::prod_t p6_prod, p8_prod;
  cfl_pkg::word_t p7_p, p9_gp;
  geo_t           p6_geo, p7_geo, p8_geo, p9_geo;

  always_ff @(posedge clk) begin
    if (en) begin
      p6_prod <= cfl_pkg::pmul(gm1_w, p5_ed);
      p6_geo  <= p5_geo;
      p7_p    <= cfl_pkg::qsc(p6_prod, FRAC_BITS);
      p7_geo  <= p6_geo;
      p8_prod <= cfl_pkg::pmul(g_w, p7_p);
      p8_geo  <= p7_geo;
      p9_gp   <= cfl_pkg::qsc(p8_prod, FRAC_BITS);
      p9_geo  <= p8_geo;
    end
  end

  // Squared sound speed c2 = gamma * p / rho.
  cfl_pkg::word_t c2_q;
  geo_t           c2_geo;

  cfl_div #(.FRAC_BITS(FRAC_BITS), .SIDE_BITS($bits(geo_t))) u_div_c2 (
    .clk(clk), .en(en), .num(p9_gp), .den(p9_geo.rho), .side_in(p9_geo),
    .quo(c2_q), .sat(), .side_out(c2_geo)
  );

  // P10/P11: clamp c2 at zero, scale by squared face lengths.
  cfl_pkg::word_t c2_pos;
  cfl_pkg::prod_t p10_x, p10_y;
  cfl_pkg::word_t p11_x, p11_y;
  vel_t           p10_vel, p11_vel;
  logic           p10_bad, p11_bad;

  assign c2_pos = c2_q[W-1] ? '0 : c2_q;

  always_ff @(posedge clk) begin
    if (en) begin
      p10_x       <= cfl_pkg::pmul(c2_pos, c2_geo.xs2);
      p10_y       <= cfl_pkg::pmul(c2_pos, c2_geo.ys2);
      p10_vel.uuc <= c2_geo.uuc;
      p10_vel.vvc <= c2_geo.vvc;
      p10_bad     <= c2_geo.bad;
      p11_x       <= cfl_pkg::qsc(p10_x, FRAC_BITS);
      p11_y       <= cfl_pkg::qsc(p10_y, FRAC_BITS);
      p11_vel     <= p10_vel;
      p11_bad     <= p10_bad;
    end
  end

  // c * |Sj| and c * |Sk|.
  cfl_pkg::word_t xsc, ysc;
  vel_t           sq_vel;
  logic           sq_bad;

  cfl_sqrt #(.FRAC_BITS(FRAC_BITS), .SIDE_BITS($bits(vel_t))) u_sqrt_x (
    .clk(clk), .en(en), .x(p11_x), .side_in(p11_vel), .y(xsc), .side_out(sq_vel)
  );

  cfl_sqrt #(.FRAC_BITS(FRAC_BITS), .SIDE_BITS(1)) u_sqrt_y (
    .clk(clk), .en(en), .x(p11_y), .side_in(p11_bad), .y(ysc), .side_out(sq_bad)
  );

  // P12/P13: spectral radius sum; flag a nonpositive sum.
  cfl_pkg::word_t p12_ea, p12_eb, p13_eig;
  logic           p12_bad, p13_bad;
  cfl_pkg::word_t eig_sum;

  assign eig_sum = cfl_pkg::sadd(p12_ea, p12_eb);

  always_ff @(posedge clk) begin
    if (en) begin
      p12_ea  <= cfl_pkg::sadd(cfl_pkg::sabs(sq_vel.uuc), xsc);
      p12_eb  <= cfl_pkg::sadd(cfl_pkg::sabs(sq_vel.vvc), ysc);
      p12_bad <= sq_bad;
      p13_eig <= eig_sum;
      p13_bad <= p12_bad || eig_sum[W-1] || (eig_sum == '0);
    end
  end

  // Time step over volume = cfl / radius sum.
  cfl_pkg::word_t dt_q;
  logic           dt_sat;
  logic           dt_bad;

  cfl_div #(.FRAC_BITS(FRAC_BITS), .SIDE_BITS(1)) u_div_dt (
    .clk(clk), .en(en), .num(cfl_w), .den(p13_eig), .side_in(p13_bad),
    .quo(dt_q), .sat(dt_sat), .side_out(dt_bad)
  );

  // Output register: invalid wins over saturation.
  always_ff @(posedge clk) begin
    if (en) begin
      if (dt_bad) begin
        out_data.dt_over_volume <= '0;
        out_data.status         <= cfl_pkg::STATUS_BAD;
      end else if (dt_sat) begin
        out_data.dt_over_volume <= 31'h7FFF_FFFF;
        out_data.status         <= cfl_pkg::STATUS_SAT;
      end else begin
        out_data.dt_over_volume <= dt_q[30:0];
        out_data.status         <= cfl_pkg::STATUS_OK;
      end
    end
  end

endmodule

@@ dv/testbench.sv @@
// Self-checking testbench for the CFL local time step core: driver, monitor and predictor.
`timescale 1ns / 100ps

module testbench;

  localparam int FRAC = 16;
  localparam int PIPE_CYCLES = 191;
  localparam int STALL_LIMIT = 20000;
  localparam int LONG_HOLD = 600;
  localparam logic [7:0] REG_UNKNOWN = 8'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  cfl_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  cfl_pkg::out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [7:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  cfl_local_timestep_2d_euler_core #(.FRAC_BITS(FRAC)) i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Predictor copy of the two registers.
  logic [30:0] courant = 31'd65536;
  logic [17:0] gamma_q = 18'd91750;

  cfl_pkg::in_t pending_cells[$];
  cfl_pkg::out_t expected_steps[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit long_hold_req = 1'b0;
  bit long_hold_done = 1'b0;
  int hold_cycles = 0;
  logic recv_hold;
  bit drain_done = 1'b0;

  assign recv_hold = long_hold_req && !long_hold_done;

  initial begin
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Fixed-point arithmetic, 64-bit signed carriers clamped to 32-bit words.
  // ---------------------------------------------------------------------
  localparam longint W_MAX = 64'sd2147483647;
  localparam longint W_MIN = -64'sd2147483648;

  function automatic longint clampw(longint a);
    return (a > W_MAX) ? W_MAX : (a < W_MIN) ? W_MIN : a;
  endfunction

  function automatic longint q_mul(longint a, longint b);
    logic [127:0] p;
    logic [127:0] m;
    bit neg;
    neg = (a < 0) != (b < 0);
    p = 128'(a < 0 ? -a : a) * 128'(b < 0 ? -b : b);
    m = p >> FRAC;
    if (neg) return (m >= 128'h8000_0000) ? W_MIN : -longint'(m);
    return (m > 128'h7FFF_FFFF) ? W_MAX : longint'(m);
  endfunction

  // Quotient (a << FRAC) / b, truncated; sat set on overflow of the word.
  function automatic longint q_div(longint a, longint b, output bit sat);
    logic [127:0] m;
    bit neg;
    neg = (a < 0) != (b < 0);
    m = (128'(a < 0 ? -a : a) << FRAC) / 128'(b < 0 ? -b : b);
    if (neg) begin
      sat = m > 128'h8000_0000;
      return (m >= 128'h8000_0000) ? W_MIN : -longint'(m);
    end
    sat = m > 128'h7FFF_FFFF;
    return sat ? W_MAX : longint'(m);
  endfunction

  function automatic longint q_sqrt(longint x);
    logic [127:0] t;
    logic [63:0] lo, hi, mid;
    if (x <= 0) return 0;
    t = 128'(x) << FRAC;
    lo = 0;
    hi = 64'd1 << 47;
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      if (128'(mid) * 128'(mid) <= t) lo = mid;
      else hi = mid - 1;
    end
    return (lo > 64'h7FFF_FFFF) ? W_MAX : longint'(lo);
  endfunction

  function automatic cfl_pkg::out_t predict_step(cfl_pkg::in_t c);
    cfl_pkg::out_t r;
    longint rho, sk0, sk1, sj0, sj1, u, v, ke, p, c2, uu, vv, xs2, ys2, eig, dt;
    bit sat;
    r.dt_over_volume = '0;
    r.status = cfl_pkg::STATUS_BAD;
    rho = longint'(c.density);
    if (rho <= 0) return r;
    sk0 = clampw(longint'(c.base_y) - longint'(c.next_j_y));
    sk1 = clampw(longint'(c.next_j_x) - longint'(c.base_x));
    sj0 = clampw(longint'(c.next_k_y) - longint'(c.base_y));
    sj1 = clampw(longint'(c.base_x) - longint'(c.next_k_x));
    u = q_div(longint'(c.momentum_x), rho, sat);
    v = q_div(longint'(c.momentum_y), rho, sat);
    ke = q_mul(64'sd32768, q_mul(rho, clampw(q_mul(u, u) + q_mul(v, v))));
    p = q_mul(longint'(gamma_q) - 65536, clampw(longint'(c.total_energy) - ke));
    c2 = q_div(q_mul(longint'(gamma_q), p), rho, sat);
    if (c2 < 0) c2 = 0;
    uu = clampw(q_mul(u, sj0) + q_mul(v, sj1));
    vv = clampw(q_mul(u, sk0) + q_mul(v, sk1));
    xs2 = clampw(q_mul(sj0, sj0) + q_mul(sj1, sj1));
    ys2 = clampw(q_mul(sk0, sk0) + q_mul(sk1, sk1));
    uu = (uu < 0) ? clampw(-uu) : uu;
    vv = (vv < 0) ? clampw(-vv) : vv;
    eig = clampw(clampw(uu + q_sqrt(q_mul(c2, xs2))) + clampw(vv + q_sqrt(q_mul(c2, ys2))));
    if (eig <= 0) return r;
    dt = q_div(longint'(courant), eig, sat);
    if (sat || dt < 0 || dt > W_MAX) begin
      r.dt_over_volume = 31'h7FFF_FFFF;
      r.status = cfl_pkg::STATUS_SAT;
    end else begin
      r.dt_over_volume = dt[30:0];
      r.status = cfl_pkg::STATUS_OK;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------
  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'h8000_0000;
      2: return 32'h7FFF_FFFF;
      default: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
    endcase
  endfunction

  // Mostly a physically plausible cell: positive density, modest momentum, non-negative
  // energy, small mesh around a random origin; some cells are random or extreme words.
  function automatic cfl_pkg::in_t rand_cell();
    cfl_pkg::in_t c;
    int ox, oy;
    if ($urandom_range(0, 9) == 0) begin
      c = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
           $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
      return c;
    end
    if ($urandom_range(0, 9) == 0) begin
      c.density = rand_word(); c.momentum_x = rand_word(); c.momentum_y = rand_word();
      c.total_energy = rand_word(); c.base_x = rand_word(); c.base_y = rand_word();
      c.next_j_x = rand_word(); c.next_j_y = rand_word();
      c.next_k_x = rand_word(); c.next_k_y = rand_word();
      return c;
    end
    ox = $urandom_range(0, 1 << 22) - (1 << 21);
    oy = $urandom_range(0, 1 << 22) - (1 << 21);
    c.density = cfl_pkg::word_t'($urandom_range(1 << 12, 1 << 20));
    c.momentum_x = cfl_pkg::word_t'($urandom_range(0, 1 << 19) - (1 << 18));
    c.momentum_y = cfl_pkg::word_t'($urandom_range(0, 1 << 19) - (1 << 18));
    c.total_energy = cfl_pkg::word_t'($urandom_range(0, 1 << 22));
    c.base_x = cfl_pkg::word_t'(ox);
    c.base_y = cfl_pkg::word_t'(oy);
    c.next_j_x = cfl_pkg::word_t'(ox + $urandom_range(1 << 10, 1 << 18));
    c.next_j_y = cfl_pkg::word_t'(oy + $urandom_range(0, 1 << 14) - (1 << 13));
    c.next_k_x = cfl_pkg::word_t'(ox + $urandom_range(0, 1 << 14) - (1 << 13));
    c.next_k_y = cfl_pkg::word_t'(oy + $urandom_range(1 << 10, 1 << 18));
    return c;
  endfunction

  function automatic cfl_pkg::in_t uniform_cell(logic [31:0] w, logic [31:0] rho);
    cfl_pkg::in_t c;
    c = {10{w}};
    c.density = cfl_pkg::word_t'(rho);
    return c;
  endfunction

  // Write one register; the config port is only touched while the core is empty.
  task automatic write_reg(logic [7:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == cfl_pkg::REG_CFL) courant = val[30:0];
    else if (idx == cfl_pkg::REG_GAMMA) gamma_q = val[17:0];
  endtask

  // Hold until the queue is drained and every expected result is back, plus
  // the pipeline depth so nothing is still in flight.
  task automatic wait_empty();
    while (pending_cells.size() != 0 || expected_steps.size() != 0 || in_valid)
      @(posedge clk);
    repeat (PIPE_CYCLES + 10) @(posedge clk);
  endtask

  task automatic load_random(int n);
    for (int i = 0; i < n; i++) pending_cells.push_back(rand_cell());
  endtask

  task automatic report_mismatch(string what, cfl_pkg::out_t got, cfl_pkg::out_t want);
    errors++;
    $display("ERROR %0t %s: got dt=%h st=%0d want dt=%h st=%0d", $realtime, what,
             got.dt_over_volume, got.status, want.dt_over_volume, want.status);
  endtask

  // ---------------------------------------------------------------------
  // Driver: present the next pending request; advance on acceptance.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) expected_steps.push_back(predict_step(in_data));
      if (pending_cells.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_data <= pending_cells.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Long receiver hold: count the held cycles, then release.
  always @(posedge clk) begin
    if (long_hold_req && !long_hold_done) begin
      if (hold_cycles >= LONG_HOLD) long_hold_done <= 1'b1;
      else hold_cycles <= hold_cycles + 1;
    end
  end

  // Receiver ready: random stalls, or a long hold when requested.
  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= !recv_hold && ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Monitor: compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_steps.size() == 0) begin
        report_mismatch("unexpected result", out_data, '0);
      end else begin
        if (out_data.dt_over_volume !== expected_steps[0].dt_over_volume)
          report_mismatch("dt_over_volume", out_data, expected_steps[0]);
        else if (out_data.status !== expected_steps[0].status)
          report_mismatch("status", out_data, expected_steps[0]);
        void'(expected_steps.pop_front());
      end
    end
  end

  // Watchdog: end the run if nothing moves for too long.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst || drain_done || (in_valid && in_ready) || (out_valid && out_ready)
        || (pending_cells.size() == 0 && expected_steps.size() == 0 && !in_valid))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------
  initial begin
    cfl_pkg::in_t c;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset registers, then extremes and special cases.
    pending_cells.push_back(uniform_cell(32'h0, 32'h0));          // zero density
    pending_cells.push_back(uniform_cell(32'h0, 32'h8000_0000));  // negative density
    pending_cells.push_back(uniform_cell(32'h0, 32'h0001_0000));  // zero eigenvalue
    pending_cells.push_back(uniform_cell(32'h7FFF_FFFF, 32'h7FFF_FFFF));
    pending_cells.push_back(uniform_cell(32'h8000_0000, 32'h0000_0001));
    pending_cells.push_back(uniform_cell(32'hFFFF_FFFF, 32'h0000_0001));
    c = uniform_cell(32'h0, 32'h0001_0000);                       // negative sound speed^2
    c.total_energy = 32'h8000_0000;
    c.next_j_x = 32'h0001_0000;
    c.next_k_y = 32'h0001_0000;
    pending_cells.push_back(c);
    c.total_energy = 32'h0002_0000;                               // ordinary unit cell
    pending_cells.push_back(c);
    c.next_j_x = 32'h0000_0001; c.next_k_y = 32'h0000_0001;      // tiny cell: zero radius sum, invalid
    pending_cells.push_back(c);
    c = uniform_cell(32'h0, 32'h0000_0001);                       // extreme corners
    c.momentum_x = 32'h7FFF_FFFF; c.momentum_y = 32'h8000_0000;
    c.base_x = 32'h8000_0000; c.next_j_x = 32'h7FFF_FFFF;
    c.base_y = 32'h7FFF_FFFF; c.next_k_y = 32'h8000_0000;
    pending_cells.push_back(c);
    for (int i = 0; i < 8; i++) pending_cells.push_back(rand_cell());
    wait_empty();

    // Extremes of both registers, plus an unknown index that must be dropped.
    write_reg(cfl_pkg::REG_CFL, 32'hFFFF_FFFF);
    write_reg(cfl_pkg::REG_GAMMA, 32'd196608);
    write_reg(REG_UNKNOWN, 32'h1234_5678);
    pending_cells.push_back(uniform_cell(32'h0, 32'h0001_0000));
    load_random(100);
    wait_empty();
    write_reg(cfl_pkg::REG_CFL, 32'd0);
    write_reg(cfl_pkg::REG_GAMMA, 32'd65536);
    load_random(100);
    wait_empty();
    write_reg(cfl_pkg::REG_GAMMA, 32'hFFFF_FFFF);                 // upper bits ignored
    load_random(50);
    wait_empty();

    // Phases with random register settings: no gaps, sender idling, receiver stalls, then both.
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(cfl_pkg::REG_CFL, $urandom_range(0, 1 << 18));
      write_reg(cfl_pkg::REG_GAMMA, $urandom_range(65536, 196608));
      send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 16 : 61) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 16 : 61) : 0;
      load_random(280);
      wait_empty();
    end

    // Back-pressure: hold the receiver off while requests keep coming.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    long_hold_req = 1'b1;
    load_random(300);
    wait (long_hold_done);
    wait_empty();

    drain_done = 1'b1;
    if (errors == 0 && expected_steps.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
